// ===== sv/ptnq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptnq_pkg: shared types and constants of the point table nearest query block
// Point layout, command and status codes, distance widths and FSM states.
// ----------------------------------------------------------------------------
package ptnq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_BITS  = 14;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_BITS  = 7;
  localparam int LIMIT_RESET = 50;
  localparam int CMP_BITS    = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int POINT_BITS  = 2 * COORD_BITS;
  localparam int DATA_BITS   = ((POINT_BITS + 7) / 8) * 8;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;

  // Squared distances are compared exactly; the search radius needs 29 bits.
  localparam longint SEARCH_RADIUS = 20000;
  localparam longint RADIUS_SQ     = SEARCH_RADIUS * SEARCH_RADIUS;
  localparam int     RADIUS_BITS   = 29;
  localparam int     DIST_BITS     = (2 * COORD_BITS + 1 > RADIUS_BITS) ?
                                     2 * COORD_BITS + 1 : RADIUS_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LIST   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_ADDED   = 3'd0,
    STAT_EXISTS  = 3'd1,
    STAT_LIMIT   = 3'd2,
    STAT_REMOVED = 3'd3,
    STAT_ABSENT  = 3'd4,
    STAT_NEAREST = 3'd5,
    STAT_ENTRY   = 3'd6,
    STAT_EMPTY   = 3'd7
  } status_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] sq_sum;
    point_t               pt;
  } dist_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESP,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

endpackage

// ===== sv/ptnq_ram.sv =====
// ----------------------------------------------------------------------------
// ptnq_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ptnq_dist.sv =====
// ----------------------------------------------------------------------------
// ptnq_dist: squared distance pipeline
// Three stages: absolute differences, squares, sum. Carries the point along.
// ----------------------------------------------------------------------------
module ptnq_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ptnq_pkg::point_t    in_pt,
  input  ptnq_pkg::point_t    query,
  output ptnq_pkg::dist_res_t res,
  output logic                busy
);

  logic                              v1, v2;
  logic [ptnq_pkg::COORD_BITS-1:0]   ad_x, ad_y;
  logic [2*ptnq_pkg::COORD_BITS-1:0] sq_x, sq_y;
  ptnq_pkg::point_t                  pt1, pt2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      res.valid <= v2;
    end
    ad_x <= (in_pt.x > query.x) ? in_pt.x - query.x : query.x - in_pt.x;
    ad_y <= (in_pt.y > query.y) ? in_pt.y - query.y : query.y - in_pt.y;
    pt1  <= in_pt;
    sq_x <= ad_x * ad_x;
    sq_y <= ad_y * ad_y;
    pt2  <= pt1;
    res.sq_sum <= ptnq_pkg::DIST_BITS'(sq_x) + ptnq_pkg::DIST_BITS'(sq_y);
    res.pt     <= pt2;
  end

  assign busy = v1 | v2 | res.valid;

endmodule

// ===== sv/point_table_nearest_query.sv =====
// ----------------------------------------------------------------------------
// point_table_nearest_query: ordered table of distinct 2-D points
// Command-driven add, remove, nearest query and list over a 64-entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, one transfer per command; the
//   command code rides in tuser, the point in tdata. Results leave on the
//   m_axis channel: status in tuser, a point in tdata, tlast on the final
//   result of a command. Add, remove and query give one result; list gives
//   one result per stored point in table order, or one empty result.
//   point_limit is written through cfg_we / cfg_wdata; the user must do so only
//   while the block is idle, since the block itself does not enforce it.
//   The single RAM read port scans one entry a cycle; a query result also
//   passes the three distance stages. A refused add and a query or list on an
//   empty table answer without a scan. list reads each entry in S_LIST_RD and
//   returns it in S_LIST_OUT. The next command can transfer in the cycle after
//   the last result of the previous one is pushed.
// Reset clears the point count (table empty) and sets point_limit to 50.
// The result waits in an output register; while the receiver stalls, the
// block finishes its work and holds, then takes the next command once the
// pending result is out of the way.
// ----------------------------------------------------------------------------
module point_table_nearest_query (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ptnq_pkg::LIMIT_BITS-1:0]  cfg_wdata,     // point_limit
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ptnq_pkg::DATA_BITS-1:0]   s_axis_tdata,  // x_coord, y_coord, zero pad
  input  logic [ptnq_pkg::CMD_BITS-1:0]    s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ptnq_pkg::DATA_BITS-1:0]   m_axis_tdata,  // point_x, point_y, zero pad
  output logic [ptnq_pkg::STATUS_BITS-1:0] m_axis_tuser,  // status
  output logic                             m_axis_tlast   // last
);

  ptnq_pkg::state_t                    state, state_next;
  ptnq_pkg::cmd_t                      cmd;
  ptnq_pkg::point_t                    qpt;
  logic [ptnq_pkg::LIMIT_BITS-1:0]     point_limit;
  logic [ptnq_pkg::COUNT_BITS-1:0]     point_count;
  logic [ptnq_pkg::COUNT_BITS-1:0]     idx;
  logic                                rd_valid;
  logic [ptnq_pkg::ADDR_BITS-1:0]      rd_idx;
  logic                                found;
  logic [ptnq_pkg::ADDR_BITS-1:0]      found_idx;
  logic                                first_seen;
  logic [ptnq_pkg::DIST_BITS-1:0]      best;
  ptnq_pkg::point_t                    pick;
  ptnq_pkg::status_t                   resp_status;

  // RAM ports
  logic                                ram_we, ram_re;
  logic [ptnq_pkg::ADDR_BITS-1:0]      ram_waddr, ram_raddr;
  ptnq_pkg::point_t                    ram_wdata, ram_rdata;

  // Distance pipeline
  logic                                dist_in_valid;
  ptnq_pkg::dist_res_t                 dist_res;
  logic                                dist_busy;

  // Handshake and status helpers
  logic                                s_accept, out_free, out_push;
  logic                                scan_more, scan_drained, list_last;
  logic                                table_full, table_empty;
  logic [ptnq_pkg::CMP_BITS-1:0]       lim_w, cnt_w, cap_w;
  ptnq_pkg::cmd_t                      cmd_in;
  ptnq_pkg::status_t                   out_status;
  ptnq_pkg::point_t                    out_pt;
  logic                                out_last;

  assign cmd_in       = ptnq_pkg::cmd_t'(s_axis_tuser);
  assign s_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign scan_more    = idx < point_count;
  assign scan_drained = !rd_valid && !dist_busy;
  assign list_last    = (idx + ptnq_pkg::COUNT_BITS'(1)) == point_count;
  assign table_empty  = point_count == '0;

  // A limit above the table depth counts as the depth.
  assign lim_w      = ptnq_pkg::CMP_BITS'(point_limit);
  assign cnt_w      = ptnq_pkg::CMP_BITS'(point_count);
  assign cap_w      = (lim_w > ptnq_pkg::CMP_BITS'(ptnq_pkg::TABLE_DEPTH)) ?
                      ptnq_pkg::CMP_BITS'(ptnq_pkg::TABLE_DEPTH) : lim_w;
  assign table_full = cnt_w >= cap_w;

  ptnq_ram #(
    .WIDTH (ptnq_pkg::POINT_BITS),
    .DEPTH (ptnq_pkg::TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Only query scans feed the distance pipeline.
  assign dist_in_valid = rd_valid && (state == ptnq_pkg::S_SCAN) &&
                         (cmd == ptnq_pkg::CMD_QUERY);

  ptnq_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dist_in_valid),
    .in_pt    (ram_rdata),
    .query    (qpt),
    .res      (dist_res),
    .busy     (dist_busy)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptnq_pkg::S_IDLE: begin
        if (s_accept) begin
          priority if (cmd_in == ptnq_pkg::CMD_ADD && table_full) begin
            state_next = ptnq_pkg::S_RESP;
          end else if ((cmd_in == ptnq_pkg::CMD_LIST || cmd_in == ptnq_pkg::CMD_QUERY)
                       && table_empty) begin
            state_next = ptnq_pkg::S_RESP;
          end else if (cmd_in == ptnq_pkg::CMD_LIST) begin
            state_next = ptnq_pkg::S_LIST_RD;
          end else begin
            state_next = ptnq_pkg::S_SCAN;
          end
        end
      end
      ptnq_pkg::S_SCAN: begin
        if (!scan_more && scan_drained) begin
          state_next = ptnq_pkg::S_DECIDE;
        end
      end
      ptnq_pkg::S_DECIDE: begin
        if (cmd == ptnq_pkg::CMD_REMOVE && found) begin
          state_next = ptnq_pkg::S_SHIFT;
        end else begin
          state_next = ptnq_pkg::S_RESP;
        end
      end
      ptnq_pkg::S_SHIFT: begin
        if (!scan_more && !rd_valid) begin
          state_next = ptnq_pkg::S_RESP;
        end
      end
      ptnq_pkg::S_RESP: begin
        if (out_free) begin
          state_next = ptnq_pkg::S_IDLE;
        end
      end
      ptnq_pkg::S_LIST_RD: begin
        state_next = ptnq_pkg::S_LIST_OUT;
      end
      ptnq_pkg::S_LIST_OUT: begin
        if (out_free) begin
          state_next = list_last ? ptnq_pkg::S_IDLE : ptnq_pkg::S_LIST_RD;
        end
      end
      default: begin
        state_next = ptnq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs per state: RAM strobes, input ready, result push
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx[ptnq_pkg::ADDR_BITS-1:0];
    ram_we        = 1'b0;
    ram_waddr     = point_count[ptnq_pkg::ADDR_BITS-1:0];
    ram_wdata     = qpt;
    out_push      = 1'b0;
    out_status    = resp_status;
    out_pt        = (resp_status == ptnq_pkg::STAT_NEAREST) ? pick : '0;
    out_last      = 1'b1;
    unique case (state)
      ptnq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ptnq_pkg::S_SCAN: begin
        ram_re = scan_more;
      end
      ptnq_pkg::S_DECIDE: begin
        // append at the end of the table
        ram_we = (cmd == ptnq_pkg::CMD_ADD) && !found;
      end
      ptnq_pkg::S_SHIFT: begin
        // read entry i while writing the entry read last cycle to i-1
        ram_re    = scan_more;
        ram_we    = rd_valid;
        ram_waddr = rd_idx - ptnq_pkg::ADDR_BITS'(1);
        ram_wdata = ram_rdata;
      end
      ptnq_pkg::S_RESP: begin
        out_push = out_free;
      end
      ptnq_pkg::S_LIST_RD: begin
        ram_re = 1'b1;
      end
      ptnq_pkg::S_LIST_OUT: begin
        out_push   = out_free;
        out_status = ptnq_pkg::STAT_ENTRY;
        out_pt     = ram_rdata;
        out_last   = list_last;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ptnq_pkg::S_IDLE;
      point_limit <= ptnq_pkg::LIMIT_BITS'(ptnq_pkg::LIMIT_RESET);
      point_count <= '0;
      rd_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= ram_re && (state == ptnq_pkg::S_SCAN || state == ptnq_pkg::S_SHIFT);
      if (cfg_we) begin
        point_limit <= cfg_wdata;
      end
      // grow on append, shrink once the shift has drained
      if (state == ptnq_pkg::S_DECIDE && cmd == ptnq_pkg::CMD_ADD && !found) begin
        point_count <= point_count + ptnq_pkg::COUNT_BITS'(1);
      end else if (state == ptnq_pkg::S_SHIFT && !scan_more && !rd_valid) begin
        point_count <= point_count - ptnq_pkg::COUNT_BITS'(1);
      end
    end
  end

  // Command datapath
  always_ff @(posedge clk) begin
    rd_idx <= ram_raddr;
    unique case (state)
      ptnq_pkg::S_IDLE: begin
        if (s_accept) begin
          cmd         <= cmd_in;
          qpt         <= s_axis_tdata[ptnq_pkg::POINT_BITS-1:0];
          idx         <= '0;
          found       <= 1'b0;
          first_seen  <= 1'b0;
          best        <= ptnq_pkg::DIST_BITS'(ptnq_pkg::RADIUS_SQ);
          resp_status <= (cmd_in == ptnq_pkg::CMD_ADD) ? ptnq_pkg::STAT_LIMIT
                                                       : ptnq_pkg::STAT_EMPTY;
        end
      end
      ptnq_pkg::S_SCAN: begin
        if (ram_re) begin
          idx <= idx + ptnq_pkg::COUNT_BITS'(1);
        end
        // first exact match wins
        if (rd_valid && !found && ram_rdata == qpt) begin
          found     <= 1'b1;
          found_idx <= rd_idx;
        end
        // strict compare keeps the earliest of equal distances; entry zero
        // stands when nothing falls inside the search radius
        if (dist_res.valid) begin
          first_seen <= 1'b1;
          if (!first_seen || dist_res.sq_sum < best) begin
            pick <= dist_res.pt;
          end
          if (dist_res.sq_sum < best) begin
            best <= dist_res.sq_sum;
          end
        end
      end
      ptnq_pkg::S_DECIDE: begin
        unique case (cmd)
          ptnq_pkg::CMD_ADD: begin
            resp_status <= found ? ptnq_pkg::STAT_EXISTS : ptnq_pkg::STAT_ADDED;
          end
          ptnq_pkg::CMD_REMOVE: begin
            resp_status <= found ? ptnq_pkg::STAT_REMOVED : ptnq_pkg::STAT_ABSENT;
          end
          ptnq_pkg::CMD_QUERY: begin
            resp_status <= ptnq_pkg::STAT_NEAREST;
          end
          ptnq_pkg::CMD_LIST: begin
            resp_status <= ptnq_pkg::STAT_EMPTY;
          end
        endcase
        idx <= ptnq_pkg::COUNT_BITS'(found_idx) + ptnq_pkg::COUNT_BITS'(1);
      end
      ptnq_pkg::S_SHIFT: begin
        if (ram_re) begin
          idx <= idx + ptnq_pkg::COUNT_BITS'(1);
        end
      end
      ptnq_pkg::S_LIST_OUT: begin
        if (out_free) begin
          idx <= idx + ptnq_pkg::COUNT_BITS'(1);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_push) begin
      m_axis_tdata <= ptnq_pkg::DATA_BITS'(out_pt);
      m_axis_tuser <= out_status;
      m_axis_tlast <= out_last;
    end
  end

endmodule

// ===== sv/ptnq_check.sv =====
// ----------------------------------------------------------------------------
// ptnq_check: port-level checks for point_table_nearest_query
// Watches the stream ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module ptnq_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptnq_pkg::DATA_BITS-1:0]   m_axis_tdata,
  input logic [ptnq_pkg::STATUS_BITS-1:0] m_axis_tuser,
  input logic                             m_axis_tlast
);

  logic no_point;

  assign no_point = m_axis_tuser == ptnq_pkg::STAT_ADDED  ||
                    m_axis_tuser == ptnq_pkg::STAT_EXISTS ||
                    m_axis_tuser == ptnq_pkg::STAT_LIMIT  ||
                    m_axis_tuser == ptnq_pkg::STAT_REMOVED ||
                    m_axis_tuser == ptnq_pkg::STAT_ABSENT ||
                    m_axis_tuser == ptnq_pkg::STAT_EMPTY;

  // one command in flight: ready drops right after a command transfer
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

  // only list entries may leave tlast low
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ptnq_pkg::STAT_ENTRY |-> m_axis_tlast)
    else $error("single result without tlast");

  // status-only results carry a zero point
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && no_point |-> m_axis_tdata == '0)
    else $error("status-only result carries a point");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // reset empties the output stage
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind point_table_nearest_query ptnq_check u_ptnq_check (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_table_nearest_query
// Drives add, remove, nearest query and list commands over several point
// limits, with random source gaps and sink stalls. A scoreboard keeps its own
// copy of the point table and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE      = 200;    // longer than a full remove with shift
  localparam int          MAX_PRINTS  = 20;
  localparam int unsigned WIDE_COORD  = (1 << ptnq_pkg::COORD_BITS) - 1;

  // One expected result transfer.
  typedef struct {
    ptnq_pkg::status_t               status;
    logic [ptnq_pkg::COORD_BITS-1:0] x;
    logic [ptnq_pkg::COORD_BITS-1:0] y;
    logic                            last;
  } result_t;

  // Tracks the point table and the point limit; queues the results each
  // accepted command must produce and checks them in order.
  class point_scoreboard;
    ptnq_pkg::point_t stored_pts[ptnq_pkg::TABLE_DEPTH];
    int unsigned      point_count;
    int unsigned      point_limit;
    result_t          pending_q[$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      peak_fill;
    int unsigned      limit_hits;
    int unsigned      far_hits;
    int unsigned      per_cmd[4];

    function new();
      point_count  = 0;
      point_limit  = ptnq_pkg::LIMIT_RESET;
      mismatches   = 0;
      results_seen = 0;
      peak_fill    = 0;
      limit_hits   = 0;
      far_hits     = 0;
      foreach (per_cmd[i]) per_cmd[i] = 0;
    endfunction

    function void set_limit(int unsigned value);
      point_limit = value & 'h7f;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // First index holding the point, or -1.
    function int find_point(ptnq_pkg::point_t p);
      for (int i = 0; i < point_count; i++) begin
        if (stored_pts[i] == p) return i;
      end
      return -1;
    endfunction

    function longint unsigned sq_dist(ptnq_pkg::point_t a, ptnq_pkg::point_t b);
      longint dx;
      longint dy;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      return longint'(dx * dx + dy * dy);
    endfunction

    function void push(ptnq_pkg::status_t st, ptnq_pkg::point_t p, logic fin);
      result_t r;
      r.status  = st;
      r.x       = p.x;
      r.y       = p.y;
      r.last    = fin;
      pending_q = {pending_q, r};
    endfunction

    // Work out the results of one accepted command and update the table.
    function void note_command(ptnq_pkg::cmd_t cmd, ptnq_pkg::point_t p);
      int unsigned       cap;
      int                at;
      int unsigned       pick;
      longint unsigned   best;
      longint unsigned   d;
      cap = (point_limit > ptnq_pkg::TABLE_DEPTH) ? ptnq_pkg::TABLE_DEPTH : point_limit;
      per_cmd[cmd]++;
      case (cmd)
        ptnq_pkg::CMD_ADD: begin
          // The limit check comes ahead of the duplicate check.
          if (point_count >= cap) begin
            limit_hits++;
            push(ptnq_pkg::STAT_LIMIT, '0, 1'b1);
          end else if (find_point(p) >= 0) begin
            push(ptnq_pkg::STAT_EXISTS, '0, 1'b1);
          end else begin
            stored_pts[point_count] = p;
            point_count++;
            if (point_count > peak_fill) peak_fill = point_count;
            push(ptnq_pkg::STAT_ADDED, '0, 1'b1);
          end
        end
        ptnq_pkg::CMD_REMOVE: begin
          at = find_point(p);
          if (at < 0) begin
            push(ptnq_pkg::STAT_ABSENT, '0, 1'b1);
          end else begin
            // Shift the later entries down one place, keeping their order.
            for (int i = at; i + 1 < point_count; i++) stored_pts[i] = stored_pts[i + 1];
            point_count--;
            push(ptnq_pkg::STAT_REMOVED, '0, 1'b1);
          end
        end
        ptnq_pkg::CMD_QUERY: begin
          if (point_count == 0) begin
            push(ptnq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            // Strictly-less keeps the earliest entry on ties; nothing inside
            // the search radius leaves entry zero as the answer.
            best = longint'(ptnq_pkg::RADIUS_SQ);
            pick = 0;
            for (int i = 0; i < point_count; i++) begin
              d = sq_dist(stored_pts[i], p);
              if (d < best) begin
                best = d;
                pick = i;
              end
            end
            if (best == longint'(ptnq_pkg::RADIUS_SQ)) far_hits++;
            push(ptnq_pkg::STAT_NEAREST, stored_pts[pick], 1'b1);
          end
        end
        default: begin
          if (point_count == 0) begin
            push(ptnq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < point_count; i++) begin
              push(ptnq_pkg::STAT_ENTRY, stored_pts[i], (i + 1 == point_count));
            end
          end
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(ptnq_pkg::status_t st, ptnq_pkg::point_t p, logic fin);
      result_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %s (%0d,%0d) last=%0b",
                                  st.name(), p.x, p.y, fin));
      end else begin
        e = pending_q.pop_front();
        if (st != e.status)
          report_mismatch($sformatf("result %0d status %s, want %s",
                                    results_seen, st.name(), e.status.name()));
        if (p.x != e.x)
          report_mismatch($sformatf("result %0d point_x %0d, want %0d",
                                    results_seen, p.x, e.x));
        if (p.y != e.y)
          report_mismatch($sformatf("result %0d point_y %0d, want %0d",
                                    results_seen, p.y, e.y));
        if (fin != e.last)
          report_mismatch($sformatf("result %0d last %0b, want %0b",
                                    results_seen, fin, e.last));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [ptnq_pkg::LIMIT_BITS-1:0]  cfg_wdata;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [ptnq_pkg::DATA_BITS-1:0]   s_axis_tdata;   // x_coord, y_coord, zero pad
  logic [ptnq_pkg::CMD_BITS-1:0]    s_axis_tuser;   // command
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [ptnq_pkg::DATA_BITS-1:0]   m_axis_tdata;   // point_x, point_y, zero pad
  logic [ptnq_pkg::STATUS_BITS-1:0] m_axis_tuser;   // status
  logic                             m_axis_tlast;   // last

  point_scoreboard  sb;
  ptnq_pkg::point_t point_pool[$];   // coordinates already used, for hits
  int               src_idle_pct;
  int               sink_idle_pct;
  int               sink_hold;
  int               cycle_count;

  point_table_nearest_query i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock: rising edges at 5, 15, ...; inputs move on falling edges.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: hold tready high or low in random bursts.
  // With idling off the receiver always accepts.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold     <= $urandom_range(0, 15);
    end
  end

  // Monitor: every transfer on either side goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(ptnq_pkg::status_t'(m_axis_tuser),
                        ptnq_pkg::point_t'(m_axis_tdata[ptnq_pkg::POINT_BITS-1:0]),
                        m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(ptnq_pkg::cmd_t'(s_axis_tuser),
                        ptnq_pkg::point_t'(s_axis_tdata[ptnq_pkg::POINT_BITS-1:0]));
    end
  end

  function automatic ptnq_pkg::point_t mk_point(int unsigned x, int unsigned y);
    ptnq_pkg::point_t p;
    p.x = ptnq_pkg::COORD_BITS'(x);
    p.y = ptnq_pkg::COORD_BITS'(y);
    return p;
  endfunction

  // Present one command and hold it until the transfer completes. An optional
  // gap with tvalid low goes in front.
  task automatic send_command(ptnq_pkg::cmd_t cmd, ptnq_pkg::point_t p);
    int gap;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ptnq_pkg::DATA_BITS'(p);
    s_axis_tuser  = cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop tvalid, drain every pending result, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = ptnq_pkg::LIMIT_BITS'(value);
    sb.set_limit(value);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly in-range coordinates, with a tight cluster for ties and a few
  // wide values that reach the top bits.
  function automatic ptnq_pkg::point_t fresh_point();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return mk_point($urandom_range(0, WIDE_COORD), $urandom_range(0, WIDE_COORD));
    if (r < 18) return mk_point($urandom_range(0, 7), $urandom_range(0, 7));
    return mk_point($urandom_range(0, 9999), $urandom_range(0, 9999));
  endfunction

  // Reuse a known point with the given odds so that exists and remove hit.
  function automatic ptnq_pkg::point_t pick_point(int reuse_pct);
    ptnq_pkg::point_t p;
    if (point_pool.size() > 0 && $urandom_range(0, 99) < reuse_pct)
      return point_pool[$urandom_range(0, point_pool.size() - 1)];
    p = fresh_point();
    point_pool = {point_pool, p};
    if (point_pool.size() > 96) point_pool.delete($urandom_range(0, 95));
    return p;
  endfunction

  // Random commands: add_pct percent adds, the rest split among remove,
  // query and list.
  task automatic run_random(int count, int add_pct);
    int rest;
    int span;
    for (int i = 0; i < count; i++) begin
      rest = int'($urandom_range(0, 99)) - add_pct;
      span = 100 - add_pct;
      if (rest < 0)
        send_command(ptnq_pkg::CMD_ADD, pick_point(15));
      else if (rest * 100 < span * 40)
        send_command(ptnq_pkg::CMD_REMOVE, pick_point(65));
      else if (rest * 100 < span * 75)
        send_command(ptnq_pkg::CMD_QUERY, pick_point(30));
      else
        send_command(ptnq_pkg::CMD_LIST, mk_point($urandom_range(0, WIDE_COORD),
                                                  $urandom_range(0, WIDE_COORD)));
    end
  endtask

  initial begin
    sb            = new();
    cycle_count   = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ptnq_pkg::CMD_LIST;
    m_axis_tready = 1'b0;
    sink_hold     = 0;
    src_idle_pct  = 25;
    sink_idle_pct = 25;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset limit: empty table, duplicates, ties,
    // a query far from every stored point, removal at each position.
    send_command(ptnq_pkg::CMD_LIST,   mk_point(0, 0));
    send_command(ptnq_pkg::CMD_QUERY,  mk_point(9999, 9999));
    send_command(ptnq_pkg::CMD_REMOVE, mk_point(0, 0));
    send_command(ptnq_pkg::CMD_ADD,    mk_point(0, 0));
    send_command(ptnq_pkg::CMD_ADD,    mk_point(0, 0));
    send_command(ptnq_pkg::CMD_ADD,    mk_point(2, 0));
    send_command(ptnq_pkg::CMD_QUERY,  mk_point(1, 0));           // tie: earliest wins
    send_command(ptnq_pkg::CMD_QUERY,  mk_point(WIDE_COORD, WIDE_COORD)); // nothing in radius
    send_command(ptnq_pkg::CMD_ADD,    mk_point(WIDE_COORD, WIDE_COORD));
    send_command(ptnq_pkg::CMD_ADD,    mk_point(9999, 0));
    send_command(ptnq_pkg::CMD_ADD,    mk_point(0, 9999));
    send_command(ptnq_pkg::CMD_ADD,    mk_point('h1555, 'h2aaa)); // alternating bits
    send_command(ptnq_pkg::CMD_QUERY,  mk_point(WIDE_COORD, WIDE_COORD));
    send_command(ptnq_pkg::CMD_QUERY,  mk_point(5000, 5000));
    send_command(ptnq_pkg::CMD_LIST,   mk_point(0, 0));
    send_command(ptnq_pkg::CMD_REMOVE, mk_point(2, 0));           // middle entry
    send_command(ptnq_pkg::CMD_REMOVE, mk_point(2, 0));
    send_command(ptnq_pkg::CMD_REMOVE, mk_point(0, 0));           // first entry
    send_command(ptnq_pkg::CMD_REMOVE, mk_point('h1555, 'h2aaa)); // last entry
    send_command(ptnq_pkg::CMD_LIST,   mk_point(0, 0));
    wait_idle();

    // Limit zero refuses every add, even one that is already present.
    write_limit(0);
    send_command(ptnq_pkg::CMD_ADD, mk_point(1, 1));
    send_command(ptnq_pkg::CMD_ADD, mk_point(9999, 0));
    wait_idle();
    // Limit below the current count.
    write_limit(2);
    send_command(ptnq_pkg::CMD_ADD, mk_point(3, 3));
    wait_idle();

    // Raise the limit to the full depth and fill the table with mostly adds.
    write_limit(ptnq_pkg::TABLE_DEPTH);
    run_random(70, 90);
    wait_idle();

    // Limit above the depth acts as the depth.
    src_idle_pct  = 10;
    sink_idle_pct = 40;
    write_limit((1 << ptnq_pkg::LIMIT_BITS) - 1);
    run_random(25, 50);
    wait_idle();

    // Smallest nonzero limit, table mostly above it.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_limit(1);
    run_random(20, 40);
    wait_idle();

    src_idle_pct  = 40;
    sink_idle_pct = 15;
    write_limit($urandom_range(2, ptnq_pkg::TABLE_DEPTH - 1));
    run_random(20, 45);
    wait_idle();

    // Closing stretch at the reset limit with no idling on either side.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_limit(ptnq_pkg::LIMIT_RESET);
    run_random(25, 40);
    wait_idle();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    $display("ran %0d list, %0d add, %0d remove, %0d query commands; %0d results checked",
             sb.per_cmd[ptnq_pkg::CMD_LIST], sb.per_cmd[ptnq_pkg::CMD_ADD],
             sb.per_cmd[ptnq_pkg::CMD_REMOVE], sb.per_cmd[ptnq_pkg::CMD_QUERY],
             sb.results_seen);
    $display("peak table fill %0d, %0d adds refused at the limit, %0d queries out of range",
             sb.peak_fill, sb.limit_hits, sb.far_hits);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ptnq_pkg.sv
sv/ptnq_ram.sv
sv/ptnq_dist.sv
sv/point_table_nearest_query.sv
sv/ptnq_check.sv
test/testbench.sv
